// ===== design/mirt_pkg.sv =====
// Shared widths, phase codes, register indexes and byte positions of the IR packet transmitter.
package mirt_pkg;

    localparam int BYTE_W    = 8;
    localparam int REG_W     = 11;
    localparam int CFG_IDX_W = 3;
    localparam int PHASE_W   = 3;
    localparam int BIDX_W    = 3;

    // phase codes
    localparam logic [PHASE_W-1:0] PH_IDLE        = 3'd0;
    localparam logic [PHASE_W-1:0] PH_START_ON    = 3'd1;
    localparam logic [PHASE_W-1:0] PH_START_OFF   = 3'd2;
    localparam logic [PHASE_W-1:0] PH_FIRST_HALF  = 3'd3;
    localparam logic [PHASE_W-1:0] PH_SECOND_HALF = 3'd4;
    localparam logic [PHASE_W-1:0] PH_GAP         = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ID_HIGH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ID_LOW    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STRENGTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_BIT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_START     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAP       = 3'd5;

    // packet byte positions
    localparam logic [BIDX_W-1:0] BYTE_ID_HIGH  = 3'd0;
    localparam logic [BIDX_W-1:0] BYTE_ID_LOW   = 3'd1;
    localparam logic [BIDX_W-1:0] BYTE_SPELL    = 3'd2;
    localparam logic [BIDX_W-1:0] BYTE_STRENGTH = 3'd3;
    localparam logic [BIDX_W-1:0] BYTE_COUNTER  = 3'd4;
    localparam logic [BIDX_W-1:0] BYTE_CHECKSUM = 3'd5;

    localparam logic [BIDX_W-1:0] MSB_BIT = 3'd7;

    // reset values of the timing registers
    localparam logic [REG_W-1:0] HALF_BIT_RESET = 11'd15;
    localparam logic [REG_W-1:0] START_RESET    = 11'd30;
    localparam logic [REG_W-1:0] GAP_RESET      = 11'd1520;

endpackage

// ===== design/mirt_cmd_if.sv =====
// Command channel: one tick or one send request per item.
interface mirt_cmd_if;
    logic                          valid;
    logic                          ready;
    logic                          mode;
    logic [mirt_pkg::BYTE_W-1:0]   spell_code;

    modport source (output valid, output mode, output spell_code, input ready);
    modport sink   (input valid, input mode, input spell_code, output ready);
endinterface

// ===== design/mirt_res_if.sv =====
// Result channel: carrier level and status flags, one item per command item.
interface mirt_res_if;
    logic valid;
    logic ready;
    logic carrier_on;
    logic busy_res;
    logic request_ignored;

    modport source (output valid, output carrier_on, output busy_res, output request_ignored,
                    input ready);
    modport sink   (input valid, input carrier_on, input busy_res, input request_ignored,
                    output ready);
endinterface

// ===== design/manchester_ir_packet_transmitter.sv =====
// Manchester IR packet transmitter: one command item in, one result item out, per clock unless stalled.
// Each command item is either a carrier-period tick (mode 0) or a send request (mode 1).
// The block takes one item every clock cycle; the result for an item appears in the
// output register on the next cycle; a new item waits while that result is not taken, so the
// only stall is an output register that is full and not being taken. A packet is a
// start burst and silence of start_ticks periods each, six bytes MSB first in Manchester
// form (one = on then off, zero = off then on, half_bit_ticks periods per half), then
// gap_ticks silent periods. Requests while busy are dropped and flagged. Phase lengths
// are capped at 2^COUNT_BITS periods.
module manchester_ir_packet_transmitter #(
    parameter int COUNT_BITS = 11
) (
    input  logic                             clk,
    input  logic                             rst_n,
    mirt_cmd_if.sink                         cmd,
    mirt_res_if.source                       result,
    input  logic                             cfg_write,
    input  logic [mirt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mirt_pkg::REG_W-1:0]       cfg_data
);

    localparam int LIM_W = (COUNT_BITS + 1 > mirt_pkg::REG_W) ? COUNT_BITS + 1 : mirt_pkg::REG_W;
    localparam logic [LIM_W-1:0] CAP = LIM_W'(1) << COUNT_BITS;

    function automatic logic [LIM_W-1:0] limit_of(input logic [mirt_pkg::REG_W-1:0] v,
                                                  input logic zero_is_one);
        logic [LIM_W-1:0] w;
        w = LIM_W'(v);
        if (zero_is_one && (v == '0))
        begin
            w = LIM_W'(1);
        end
        if (w > CAP)
        begin
            w = CAP;
        end
        return w;
    endfunction

    // configuration
    logic [mirt_pkg::BYTE_W-1:0] id_high_reg, id_low_reg, strength_reg;
    logic [mirt_pkg::REG_W-1:0]  half_bit_reg, start_reg, gap_reg;

    // packet state
    logic [mirt_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic [COUNT_BITS-1:0]        count_reg, count_next;
    logic [mirt_pkg::BIDX_W-1:0]  byte_idx_reg, byte_idx_next;
    logic [mirt_pkg::BIDX_W-1:0]  bit_idx_reg, bit_idx_next;
    logic [mirt_pkg::BYTE_W-1:0]  spell_reg, spell_next;
    logic [mirt_pkg::BYTE_W-1:0]  uuid_reg, uuid_next;
    logic [mirt_pkg::BYTE_W-1:0]  checksum_reg, checksum_next;

    // output register
    logic res_valid_reg, res_valid_next;
    logic carrier_reg, busy_reg, ignored_reg;
    logic carrier_c, busy_c, ignored_c;

    logic                        accept;
    logic [LIM_W-1:0]            start_lim, half_lim, gap_lim, lim;
    logic [LIM_W-1:0]            count_inc;
    logic                        done;
    logic [mirt_pkg::BYTE_W-1:0] cur_byte;
    logic                        cur_bit;
    logic [mirt_pkg::BYTE_W-1:0] byte_sum;

    assign cmd.ready  = !res_valid_reg || result.ready;
    assign accept     = cmd.valid && cmd.ready;

    assign result.valid           = res_valid_reg;
    assign result.carrier_on      = carrier_reg;
    assign result.busy_res        = busy_reg;
    assign result.request_ignored = ignored_reg;

    assign start_lim = limit_of(start_reg, 1'b1);
    assign half_lim  = limit_of(half_bit_reg, 1'b1);
    assign gap_lim   = limit_of(gap_reg, 1'b0);
    assign count_inc = LIM_W'(count_reg) + LIM_W'(1);
    assign done      = (count_inc >= lim);
    assign cur_bit   = cur_byte[bit_idx_reg];
    assign byte_sum  = id_high_reg + id_low_reg + cmd.spell_code + strength_reg + uuid_reg;

    always_comb
    begin
        unique case (phase_reg) inside
            mirt_pkg::PH_START_ON, mirt_pkg::PH_START_OFF:     lim = start_lim;
            mirt_pkg::PH_FIRST_HALF, mirt_pkg::PH_SECOND_HALF: lim = half_lim;
            default:                                           lim = gap_lim;
        endcase
    end

    always_comb
    begin
        unique case (byte_idx_reg)
            mirt_pkg::BYTE_ID_HIGH:  cur_byte = id_high_reg;
            mirt_pkg::BYTE_ID_LOW:   cur_byte = id_low_reg;
            mirt_pkg::BYTE_SPELL:    cur_byte = spell_reg;
            mirt_pkg::BYTE_STRENGTH: cur_byte = strength_reg;
            mirt_pkg::BYTE_COUNTER:  cur_byte = uuid_reg;
            default:                 cur_byte = checksum_reg;
        endcase
    end

    always_comb
    begin
        phase_next    = phase_reg;
        count_next    = count_reg;
        byte_idx_next = byte_idx_reg;
        bit_idx_next  = bit_idx_reg;
        spell_next    = spell_reg;
        uuid_next     = uuid_reg;
        checksum_next = checksum_reg;
        carrier_c     = 1'b0;
        busy_c        = 1'b0;
        ignored_c     = 1'b0;

        if (accept)
        begin
            if (cmd.mode)
            begin
                busy_c = 1'b1;
                if (phase_reg != mirt_pkg::PH_IDLE)
                begin
                    ignored_c = 1'b1;
                end
                else
                begin
                    spell_next    = cmd.spell_code;
                    checksum_next = ~byte_sum;
                    phase_next    = mirt_pkg::PH_START_ON;
                    count_next    = '0;
                    byte_idx_next = mirt_pkg::BYTE_ID_HIGH;
                    bit_idx_next  = mirt_pkg::MSB_BIT;
                end
            end
            else if (phase_reg != mirt_pkg::PH_IDLE)
            begin
                busy_c     = 1'b1;
                count_next = done ? '0 : count_inc[COUNT_BITS-1:0];
                unique case (phase_reg)
                    mirt_pkg::PH_START_ON:
                    begin
                        carrier_c = 1'b1;
                        if (done)
                        begin
                            phase_next = mirt_pkg::PH_START_OFF;
                        end
                    end
                    mirt_pkg::PH_START_OFF:
                    begin
                        if (done)
                        begin
                            phase_next    = mirt_pkg::PH_FIRST_HALF;
                            byte_idx_next = mirt_pkg::BYTE_ID_HIGH;
                            bit_idx_next  = mirt_pkg::MSB_BIT;
                        end
                    end
                    mirt_pkg::PH_FIRST_HALF:
                    begin
                        carrier_c = cur_bit;
                        if (done)
                        begin
                            phase_next = mirt_pkg::PH_SECOND_HALF;
                        end
                    end
                    mirt_pkg::PH_SECOND_HALF:
                    begin
                        carrier_c = ~cur_bit;
                        if (done)
                        begin
                            if (bit_idx_reg != '0)
                            begin
                                bit_idx_next = bit_idx_reg - 1'b1;
                                phase_next   = mirt_pkg::PH_FIRST_HALF;
                            end
                            else if (byte_idx_reg < mirt_pkg::BYTE_CHECKSUM)
                            begin
                                byte_idx_next = byte_idx_reg + 1'b1;
                                bit_idx_next  = mirt_pkg::MSB_BIT;
                                phase_next    = mirt_pkg::PH_FIRST_HALF;
                            end
                            else
                            begin
                                uuid_next     = uuid_reg + 1'b1;
                                byte_idx_next = '0;
                                bit_idx_next  = '0;
                                phase_next    = (gap_lim == '0) ? mirt_pkg::PH_IDLE
                                                                : mirt_pkg::PH_GAP;
                            end
                        end
                    end
                    default:
                    begin
                        if (done)
                        begin
                            phase_next = mirt_pkg::PH_IDLE;
                        end
                    end
                endcase
            end
        end

        if (accept)
        begin
            res_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_high_reg   <= '0;
            id_low_reg    <= '0;
            strength_reg  <= '0;
            half_bit_reg  <= mirt_pkg::HALF_BIT_RESET;
            start_reg     <= mirt_pkg::START_RESET;
            gap_reg       <= mirt_pkg::GAP_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                mirt_pkg::REG_ID_HIGH:  id_high_reg  <= cfg_data[mirt_pkg::BYTE_W-1:0];
                mirt_pkg::REG_ID_LOW:   id_low_reg   <= cfg_data[mirt_pkg::BYTE_W-1:0];
                mirt_pkg::REG_STRENGTH: strength_reg <= cfg_data[mirt_pkg::BYTE_W-1:0];
                mirt_pkg::REG_HALF_BIT: half_bit_reg <= cfg_data;
                mirt_pkg::REG_START:    start_reg    <= cfg_data;
                mirt_pkg::REG_GAP:      gap_reg      <= cfg_data;
                default:                ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= mirt_pkg::PH_IDLE;
            count_reg     <= '0;
            byte_idx_reg  <= '0;
            bit_idx_reg   <= '0;
            spell_reg     <= '0;
            uuid_reg      <= '0;
            checksum_reg  <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            byte_idx_reg  <= byte_idx_next;
            bit_idx_reg   <= bit_idx_next;
            spell_reg     <= spell_next;
            uuid_reg      <= uuid_next;
            checksum_reg  <= checksum_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            carrier_reg <= carrier_c;
            busy_reg    <= busy_c;
            ignored_reg <= ignored_c;
        end
    end

`ifndef NO_ASSERTIONS
    a_ignored_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && ignored_reg |-> busy_reg)
        else $error("dropped request not flagged busy");

    a_carrier_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && carrier_reg |-> busy_reg)
        else $error("carrier on outside a packet");

    a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == mirt_pkg::PH_IDLE |-> count_reg == '0)
        else $error("period counter not cleared in idle");

    a_byte_range: assert property (@(posedge clk) disable iff (!rst_n)
        byte_idx_reg <= mirt_pkg::BYTE_CHECKSUM)
        else $error("byte index past checksum");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !result.ready |=> res_valid_reg && $stable(carrier_reg))
        else $error("stalled result lost");
`endif

endmodule
